// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers for the RTL, checked outside reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`endif

// ===== src/dqdel_pkg.sv =====
// ----------------------------------------------------------------------------
// dqdel_pkg
// Shared types and codes for the deque with delete by value.
// ----------------------------------------------------------------------------
package dqdel_pkg;
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_REMOVE     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic       exec;
        logic [2:0] func;
    } dqdel_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic found;
    } dqdel_stat_t;
endpackage

// ===== src/dqdel_datapath.sv =====
// ----------------------------------------------------------------------------
// dqdel_datapath
// Cell array with parallel compare and shift, entry count and result fields.
// ----------------------------------------------------------------------------
module dqdel_datapath import dqdel_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dqdel_cmd_t         cmd,
    input  logic signed [31:0] item_value,
    output dqdel_stat_t        stat,
    output logic [4:0]         entry_count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   cell_reg [CAPACITY];
    logic [CW-1:0] count_reg, count_next;
    logic [CAPACITY-1:0] hit, before_hit, valid;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid[i] = (CW'(i) < count_reg);
            hit[i]   = valid[i] && (cell_reg[i] == item_value);
        end
        // before_hit[i]: some hit at index <= i
        before_hit[0] = hit[0];
        for (int i = 1; i < CAPACITY; i++)
            before_hit[i] = before_hit[i-1] | hit[i];
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(CAPACITY));
    assign stat.found = |hit;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec)
        begin
            case (cmd.func) inside
                FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                    if (!stat.full) count_next = count_reg + 1'b1;
                FUNC_POP_FRONT, FUNC_POP_BACK:
                    if (!stat.empty) count_next = count_reg - 1'b1;
                FUNC_REMOVE:
                    if (stat.found) count_next = count_reg - 1'b1;
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            case (cmd.func)
                FUNC_PUSH_FRONT:
                    if (!stat.full)
                    begin
                        cell_reg[0] <= item_value;
                        for (int i = 1; i < CAPACITY; i++)
                            cell_reg[i] <= cell_reg[i-1];
                    end
                FUNC_PUSH_BACK:
                    if (!stat.full)
                        cell_reg[count_reg[CW-1:0] < CW'(CAPACITY) ?
                                 count_reg[$clog2(CAPACITY)-1:0] : '0] <= item_value;
                FUNC_POP_FRONT:
                    for (int i = 0; i < CAPACITY - 1; i++)
                        cell_reg[i] <= cell_reg[i+1];
                FUNC_REMOVE:
                    // close the gap from the first hit onward
                    for (int i = 0; i < CAPACITY - 1; i++)
                        if (before_hit[i])
                            cell_reg[i] <= cell_reg[i+1];
                default: ;
            endcase
        end
    end

    logic [$clog2(CAPACITY)-1:0] last_idx;
    assign last_idx    = $clog2(CAPACITY)'(count_reg - 1'b1);
    assign entry_count = 5'(count_reg);
    assign front_value = stat.empty ? 32'sd0 : cell_reg[0];
    assign back_value  = stat.empty ? 32'sd0 : cell_reg[last_idx];
endmodule

// ===== src/dqdel_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqdel_ctrl
// Controller: takes a request, runs it on the datapath, presents the result.
// ----------------------------------------------------------------------------
module dqdel_ctrl import dqdel_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  dqdel_stat_t stat,
    output dqdel_cmd_t  cmd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status
);
    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_SHOW = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign in_stall  = (state_reg != S_EXEC);
    assign cmd.exec  = (state_reg == S_EXEC) && in_valid;
    assign cmd.func  = func;
    assign out_valid = (state_reg == S_SHOW);
    assign status    = status_reg;

    always_comb
    begin
        status_next = status_reg;
        state_next  = state_reg;
        unique case (state_reg)
            S_EXEC:
                if (in_valid)
                begin
                    state_next = S_SHOW;
                    case (func) inside
                        FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                            status_next = stat.full ? ST_FULL : ST_OK;
                        FUNC_POP_FRONT, FUNC_POP_BACK:
                            status_next = stat.empty ? ST_EMPTY : ST_OK;
                        FUNC_REMOVE:
                            status_next = stat.empty ? ST_EMPTY :
                                          (stat.found ? ST_OK : ST_NOTFOUND);
                        default: status_next = ST_OK;
                    endcase
                end
            S_SHOW:
                if (!out_stall) state_next = S_EXEC;
            default: state_next = S_EXEC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_EXEC;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end
endmodule

// ===== src/deque_with_delete_by_value.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value
// Bounded deque of signed values with push/pop at both ends and remove by value.
// ----------------------------------------------------------------------------
// Each request beat executes when it is accepted: all cells compare against the
// value in parallel and shift together. The result beat is held until taken; the
// next request is accepted in the cycle after the result leaves, so no new
// request is taken while a result is still pending.
`include "assert_macros.svh"
module deque_with_delete_by_value import dqdel_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value
);
    dqdel_cmd_t  cmd;
    dqdel_stat_t stat;

    dqdel_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .stat(stat), .cmd(cmd), .out_valid(out_valid),
        .out_stall(out_stall), .status(status)
    );

    dqdel_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item_value(item_value),
        .stat(stat), .entry_count(entry_count),
        .front_value(front_value), .back_value(back_value)
    );

    `ASSERT_IMPL(a_no_accept_while_out, clk, rst_n, out_valid, in_stall,
                 "accept during result")
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && entry_count == 5'd0,
                 front_value == 32'sd0 && back_value == 32'sd0,
                 "empty list shows nonzero")
    `ASSERT_IMPL(a_full_keeps, clk, rst_n, out_valid && status == ST_FULL,
                 entry_count == 5'(CAPACITY), "full status with room")
endmodule
